// ----- sv/rgbmf_pkg.sv -----
// Package for the RGB window median filter: payload structs, sizes and
// the rank target table. No dependencies.
`default_nettype none
package rgbmf_pkg;

  localparam int MAX_RADIUS = 3;
  localparam int MAX_WIDTH  = 2048;
  localparam int LEVELS     = 256;
  localparam int SIDE_MAX   = 2 * MAX_RADIUS + 1;
  localparam int LINES_MAX  = 2 * MAX_RADIUS;
  localparam int CH_W       = $clog2(LEVELS);
  localparam int PIX_W      = 3 * CH_W;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 16;
  localparam int CNT_W      = $clog2(SIDE_MAX * SIDE_MAX + 1);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0]  med_red;
    logic [CH_W-1:0]  med_green;
    logic [CH_W-1:0]  med_blue;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
  } med_out_t;

  // Rank of the median, counted from zero, for a window of side 2r+1.
  function automatic logic [CNT_W-1:0] rank_target(input logic [1:0] r);
    logic [CNT_W-1:0] t;
    case (r)
      2'd0:    t = CNT_W'(0);
      2'd1:    t = CNT_W'(4);
      2'd2:    t = CNT_W'(12);
      default: t = CNT_W'(24);
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- sv/rgb_window_median_filter.sv -----
// Top level of the RGB window median filter: line memory, window registers,
// frame counters and a bit-serial rank selector. Depends on rgbmf_pkg.
`default_nettype none
//  Channel | Ports                                  | Carries
//  --------+----------------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data            | one source pixel
//  output  | out_valid, out_ready, out_data         | medians and window centre
//  config  | psel, penable, pwrite, paddr, pwdata,  | radius, width, height
//          | prdata, pready                         |
//
// A pixel that yields no result goes through a line memory read, then an update.
// A pixel that yields a result then also goes through the selector, which settles
// one median bit per pass and counts one window row per cycle.
// The output register holds a result while the next pixel is accepted.
// Reset is synchronous, active low; the line memory and window are not cleared.
// A configuration write restarts the frame counters.
module rgb_window_median_filter (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  rgbmf_pkg::pix_in_t       in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output rgbmf_pkg::med_out_t      out_data,
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire  [3:0]               paddr,
  input  wire  [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import rgbmf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  typedef logic [LINES_MAX-1:0][PIX_W-1:0] line_word_t;
  typedef logic [SIDE_MAX-1:0][PIX_W-1:0]  win_row_t;

  logic [1:0]        state_r;
  logic [1:0]        radius_r;
  logic [11:0]       width_r;
  logic [15:0]       height_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic              cfg_wr;
  logic [11:0]       w_eff;
  logic [15:0]       h_eff;
  logic [2:0]        side;
  logic [2:0]        lines;

  line_word_t        line_mem [MAX_WIDTH];
  line_word_t        rd_r;
  line_word_t        wr_data;
  logic [PIX_W-1:0]  pix_r;
  win_row_t          win_r [SIDE_MAX];
  logic [PIX_W-1:0]  vec [SIDE_MAX];

  logic              emit;
  logic [ROW_W-1:0]  res_row_r;
  logic [COL_W-1:0]  res_col_r;
  logic [11:0]       col_inc;
  logic [16:0]       row_inc;

  logic [2:0]        a_r;
  logic [2:0]        bit_r;
  logic [CH_W-1:0]   prefix_r [3];
  logic [CH_W-1:0]   prefix_nxt [3];
  logic [CNT_W-1:0]  rem_r [3];
  logic [CNT_W-1:0]  rem_nxt [3];
  logic [CNT_W-1:0]  cnt_r [3];
  logic [CNT_W-1:0]  cnt_sum [3];
  logic [CH_W-1:0]   hi_mask;
  logic              last_row;
  logic              out_load;
  med_out_t          out_r;
  logic              out_valid_r;

  // Configuration port and effective register values.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[3:2] != 2'd3);
  assign w_eff  = (width_r == 12'd0) ? 12'd1 :
                  (width_r > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : width_r;
  assign h_eff  = (height_r == 16'd0) ? 16'd1 : height_r;
  assign side   = {radius_r, 1'b1};
  assign lines  = {radius_r, 1'b0};

  always_comb begin
    unique case (paddr[3:2])
      REG_RADIUS: prdata = {30'd0, radius_r};
      REG_WIDTH:  prdata = {20'd0, width_r};
      REG_HEIGHT: prdata = {16'd0, height_r};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 2'd1;
      width_r  <= 12'd2048;
      height_r <= 16'd1024;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RADIUS: radius_r <= pwdata[1:0];
        REG_WIDTH:  width_r  <= pwdata[11:0];
        REG_HEIGHT: height_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Column of new lines: the fresh pixel on top, older lines shifted down.
  always_comb begin
    vec[0] = pix_r;
    for (int k = 1; k < SIDE_MAX; k++) vec[k] = rd_r[k-1];
    for (int k = 0; k < LINES_MAX; k++)
      wr_data[k] = (3'(k) < lines) ? vec[k] : rd_r[k];
  end

  // Line memory: one word holds all stored lines of one column.
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) line_mem[col_r] <= wr_data;
    rd_r <= line_mem[col_r];
  end

  // Window shift and input capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) pix_r <= in_data;
    if (state_r == ST_LOAD) begin
      for (int k = 0; k < SIDE_MAX; k++)
        win_r[k] <= {win_r[k][SIDE_MAX-2:0], vec[k]};
    end
  end

  // Frame counters and result position.
  assign emit    = (row_r >= ROW_W'(lines)) && (col_r >= COL_W'(lines));
  assign col_inc = {1'b0, col_r} + 12'd1;
  assign row_inc = {1'b0, row_r} + 17'd1;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (state_r == ST_LOAD) begin
      if (col_inc >= w_eff) begin
        col_r <= '0;
        row_r <= (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_r <= col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      res_row_r <= row_r - ROW_W'(radius_r);
      res_col_r <= col_r - COL_W'(radius_r);
    end
  end

  // Rank selector: per pass, count window values that match the settled
  // upper bits and have a zero at the current bit, one row per cycle.
  assign hi_mask  = ~((8'd2 << bit_r) - 8'd1);
  assign last_row = (a_r == lines);

  always_comb begin
    logic [2:0]      rowcnt;
    logic [CH_W-1:0] v;
    for (int ch = 0; ch < 3; ch++) begin
      rowcnt = 3'd0;
      for (int c = 0; c < SIDE_MAX; c++) begin
        v = win_r[a_r][c][8*ch +: 8];
        if ((3'(c) < side) && (((v ^ prefix_r[ch]) & hi_mask) == 8'd0) && !v[bit_r])
          rowcnt = rowcnt + 3'd1;
      end
      cnt_sum[ch]    = cnt_r[ch] + CNT_W'(rowcnt);
      prefix_nxt[ch] = prefix_r[ch];
      rem_nxt[ch]    = rem_r[ch];
      if (rem_r[ch] >= cnt_sum[ch]) begin
        prefix_nxt[ch][bit_r] = 1'b1;
        rem_nxt[ch]           = rem_r[ch] - cnt_sum[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      a_r   <= 3'd0;
      bit_r <= 3'd7;
      for (int ch = 0; ch < 3; ch++) begin
        prefix_r[ch] <= '0;
        rem_r[ch]    <= rank_target(radius_r);
        cnt_r[ch]    <= '0;
      end
    end else if (state_r == ST_SEL) begin
      if (last_row) begin
        a_r   <= 3'd0;
        bit_r <= bit_r - 3'd1;
        for (int ch = 0; ch < 3; ch++) begin
          prefix_r[ch] <= prefix_nxt[ch];
          rem_r[ch]    <= rem_nxt[ch];
          cnt_r[ch]    <= '0;
        end
      end else begin
        a_r <= a_r + 3'd1;
        for (int ch = 0; ch < 3; ch++) cnt_r[ch] <= cnt_sum[ch];
      end
    end
  end

  // Sequencer. No transaction is taken while reset is held.
  assign in_ready = rst_n && (state_r == ST_IDLE);
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: if (in_valid) state_r <= ST_LOAD;
        ST_LOAD: state_r <= emit ? ST_SEL : ST_IDLE;
        ST_SEL:  if (last_row && bit_r == 3'd0) state_r <= ST_FIN;
        ST_FIN:  if (out_load) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.med_red   <= prefix_r[2];
      out_r.med_green <= prefix_r[1];
      out_r.med_blue  <= prefix_r[0];
      out_r.out_row   <= res_row_r;
      out_r.out_col   <= res_col_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The selector row index stays inside the active window.
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEL |-> a_r <= lines)
    else $error("selector row beyond window");

  // A result is only finished after the last bit pass.
  a_fin_bit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |-> bit_r == 3'd7 && $past(bit_r == 3'd0 || state_r == ST_FIN))
    else $error("result finished before all bits settled");

  // Frame counters stay inside the configured frame.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < w_eff)
    else $error("column counter beyond frame width");

  a_row_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    row_r < h_eff)
    else $error("row counter beyond frame height");

endmodule
`default_nettype wire

// ----- dv/tb_rgb_window_median_filter.sv -----
// Self-checking testbench for the RGB window median filter: drives pixels
// and register writes, predicts medians and window centres. Depends on rgbmf_pkg.
`timescale 1ns / 100ps
module tb_rgb_window_median_filter;
  import rgbmf_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 80;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  pix_in_t in_data;
  logic out_valid;
  logic out_ready;
  med_out_t out_data;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rgb_window_median_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: line memory, window, counters and registers.
  logic [PIX_W-1:0] model_lines [LINES_MAX][MAX_WIDTH];
  logic [PIX_W-1:0] model_win [SIDE_MAX][SIDE_MAX];
  int unsigned model_row, model_col;
  int unsigned reg_radius, reg_width, reg_height;

  med_out_t median_queue[$];
  int mismatches;
  int cycles;
  bit quiet_out;

  // Directed stimulus: pixel plus an optional result typed in by hand.
  typedef struct {
    pix_in_t pix;
    bit      has_fixed;
    med_out_t fixed;
  } stim_row_t;
  stim_row_t stim_rows[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [CH_W-1:0] rank_pick(int side, int sh);
    int hist[LEVELS];
    int target, acc;
    for (int v = 0; v < LEVELS; v++) hist[v] = 0;
    for (int a = 0; a < side; a++)
      for (int b = 0; b < side; b++)
        hist[(model_win[a][b] >> sh) & 8'hFF]++;
    target = (side * side - 1) / 2;
    acc = 0;
    for (int v = 0; v < LEVELS; v++) begin
      acc += hist[v];
      if (acc > target) return CH_W'(v);
    end
    return CH_W'(LEVELS - 1);
  endfunction

  // Advance the predictor by one pixel; returns 1 and the result if emitted.
  function automatic bit predict_median(input pix_in_t p, output med_out_t res);
    int unsigned r, side, lines, w, h, col;
    logic [PIX_W-1:0] column_vec [SIDE_MAX];
    bit emit;
    r = (reg_radius > MAX_RADIUS) ? MAX_RADIUS : reg_radius;
    side = 2 * r + 1;
    lines = 2 * r;
    w = (reg_width == 0) ? 1 : ((reg_width > MAX_WIDTH) ? MAX_WIDTH : reg_width);
    h = (reg_height == 0) ? 1 : reg_height;
    col = (model_col < MAX_WIDTH) ? model_col : MAX_WIDTH - 1;
    column_vec[0] = {p.in_red, p.in_green, p.in_blue};
    for (int k = 1; k <= lines; k++) column_vec[k] = model_lines[k-1][col];
    for (int k = 0; k < lines; k++) model_lines[k][col] = column_vec[k];
    for (int k = 0; k < side; k++) begin
      for (int c = side - 1; c > 0; c--) model_win[k][c] = model_win[k][c-1];
      model_win[k][0] = column_vec[k];
    end
    emit = (model_row >= lines) && (model_col >= lines);
    res = '0;
    if (emit) begin
      res.med_red   = rank_pick(side, 16);
      res.med_green = rank_pick(side, 8);
      res.med_blue  = rank_pick(side, 0);
      res.out_row   = ROW_W'(model_row - r);
      res.out_col   = COL_W'(model_col - r);
    end
    model_col++;
    if (model_col >= w) begin
      model_col = 0;
      model_row++;
      if (model_row >= h) model_row = 0;
    end
    return emit;
  endfunction

  // One APB write, setup then access phase.
  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_RADIUS: reg_radius = value & 32'h3;
      REG_WIDTH:  reg_width  = value & 32'hFFF;
      default:    reg_height = value & 32'hFFFF;
    endcase
    model_row = 0;
    model_col = 0;
  endtask

  // Wait for all expected results, then let any non-emitting pixel finish.
  task automatic wait_idle();
    while (median_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_geometry(int unsigned r, int unsigned w, int unsigned h);
    wait_idle();
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Present one pixel, optionally after a random gap, and record its result.
  task automatic send_pixel(input pix_in_t p, input bit may_idle,
                            input bit has_fixed, input med_out_t fixed);
    med_out_t res;
    if (may_idle && ($urandom_range(0, 3) == 0)) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = p;
    do @(posedge clk); while (!in_ready);
    if (predict_median(p, res)) begin
      if (has_fixed) res = fixed;
      median_queue.push_back(res);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic pix_in_t rand_pixel();
    pix_in_t p;
    p = pix_in_t'(24'($urandom));
    return p;
  endfunction

  // Result checker on the output transaction.
  always @(posedge clk) begin
    med_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (median_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction %h", out_data);
      end else begin
        want = median_queue.pop_front();
        if (want.med_red !== out_data.med_red || want.med_green !== out_data.med_green ||
            want.med_blue !== out_data.med_blue || want.out_row !== out_data.out_row ||
            want.out_col !== out_data.out_col) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Median mismatch: expected %h, got %h", want, out_data);
        end
      end
    end
  end

  // Receiver stall bursts, switched off for the final stretch.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet_out && ($urandom_range(0, 3) == 0)) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  initial begin
    stim_row_t row;
    int unsigned w, h, r, n;
    mismatches = 0;
    cycles = 0;
    quiet_out = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    reg_radius = 1; reg_width = 2048; reg_height = 1024;
    model_row = 0; model_col = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed: radius 1 over a 3x3 frame; one window of all-white and
    // all-black mixes to hit the channel extremes.
    set_geometry(1, 3, 3);
    for (int i = 0; i < 9; i++) begin
      row.pix = (i % 2 == 0) ? pix_in_t'(24'hFFFFFF) : pix_in_t'(24'h000000);
      row.has_fixed = (i == 8);
      row.fixed = '{med_red: 8'hFF, med_green: 8'hFF, med_blue: 8'hFF,
                    out_row: 16'd1, out_col: 11'd1};
      stim_rows.push_back(row);
    end
    // Second frame with mixed channels, checked by the predictor.
    for (int i = 0; i < 9; i++) begin
      row.pix = pix_in_t'({8'(i * 31), 8'(255 - i * 17), 8'(i[0] ? 8'hFF : 8'h00)});
      row.has_fixed = 1'b0;
      stim_rows.push_back(row);
    end
    foreach (stim_rows[i]) send_pixel(stim_rows[i].pix, 1'b0, stim_rows[i].has_fixed,
                                      stim_rows[i].fixed);

    // Radius zero: every pixel is its own median.
    set_geometry(0, 1, 1);
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel(), 1'b0, 1'b0, '0);

    // Window larger than the frame: no results at all.
    set_geometry(3, 4, 4);
    for (int i = 0; i < 16; i++) send_pixel(rand_pixel(), 1'b1, 1'b0, '0);

    // Random phases: every frame is filled from its start, so every line memory
    // read that feeds a result hits a pixel already written in this configuration.
    n = 0;
    while (n < 340) begin
      r = $urandom_range(0, 3);
      w = $urandom_range(2 * r + 1, 2 * r + 6);
      h = $urandom_range(2 * r + 1, 2 * r + 4);
      case ($urandom_range(0, 9))
        0: w = 2048;
        1: h = 65535;
        default: ;
      endcase
      set_geometry(r, w, h);
      if (n > 270) quiet_out = 1'b1;
      for (int i = 0; i < w * (2 * r + 2) && i < 120; i++) begin
        send_pixel(rand_pixel(), !quiet_out, 1'b0, '0);
        n++;
      end
      // Sometimes the sender holds off until the block has delivered everything.
      if ($urandom_range(0, 2) == 0) while (median_queue.size() != 0) @(negedge clk);
    end

    // Full frame wrap on a small frame at maximum radius.
    set_geometry(3, 7, 7);
    for (int i = 0; i < 98; i++) send_pixel(rand_pixel(), 1'b0, 1'b0, '0);

    wait_idle();
    if (mismatches == 0 && median_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
